FILE: hw/rtl/ssi_pkg.sv
package ssi_pkg;

    // number of quotient bits of the point division
    localparam int QB = 34;

    typedef logic signed [31:0]  t_crd;
    typedef logic signed [32:0]  t_dif;
    typedef logic signed [32:0]  t_limb;
    typedef logic signed [65:0]  t_pp;
    typedef logic signed [67:0]  t_dot;
    typedef logic signed [191:0] t_w;
    typedef logic signed [351:0] t_q;
    typedef logic [175:0]        t_dn;
    typedef logic [QB-1:0]       t_quo;
    typedef logic [11:0][31:0]   t_pts;
    typedef t_pp t_ppa [0:5][0:5];

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_S1   = 3'd1,
        KIND_E1   = 3'd2,
        KIND_S2   = 3'd3,
        KIND_E2   = 3'd4,
        KIND_NEW  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_DET_EPS  = 2'd0,
        CFG_COIN_EPS = 2'd1,
        CFG_ZERO_EPS = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

    // what travels beside the quotient through the divider
    typedef struct packed {
        t_kind kind;
        t_pts  pts;
    } t_side;

    // one 32-bit digit of a wide signed value; the top digit carries the sign
    function automatic t_limb limb(input t_w x, input int i, input int n);
        t_w sh;
        sh = x >>> (32 * i);
        if (i == n - 1) begin
            return $signed(sh[32:0]);
        end
        return $signed({1'b0, sh[31:0]});
    endfunction

    // digit-by-digit partial products of a wide multiply
    function automatic t_ppa mk_pp(input t_w a, input t_w b, input int na, input int nb);
        t_ppa r;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) begin
                if (i < na && j < nb) begin
                    r[i][j] = limb(a, i, na) * limb(b, j, nb);
                end else begin
                    r[i][j] = '0;
                end
            end
        end
        return r;
    endfunction

    // collect partial products into a product of moderate width
    function automatic t_w sum_w(input t_ppa p);
        t_w acc;
        acc = '0;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) begin
                acc = acc + (t_w'(p[i][j]) <<< (32 * (i + j)));
            end
        end
        return acc;
    endfunction

    // one row of partial products of a very wide product
    function automatic t_q row_q(input t_ppa p, input int i);
        t_q acc;
        acc = '0;
        for (int j = 0; j < 6; j++) begin
            acc = acc + (t_q'(p[i][j]) <<< (32 * (i + j)));
        end
        return acc;
    endfunction

    function automatic t_w abs_w(input t_w x);
        return (x < 0) ? -x : x;
    endfunction

endpackage

FILE: hw/rtl/ssi_div.sv
module ssi_div import ssi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_dn [2:0]    i_num,
    input  t_dn          i_den,
    input  t_side        i_side,
    output logic         o_valid,
    output t_quo [2:0]   o_quo,
    output t_side        o_side
);

    logic  r_v    [QB];
    t_dn   r_rem  [QB][3];
    t_quo  r_quo  [QB][3];
    t_dn   r_den  [QB];
    t_side r_side [QB];

    t_dn   n_rem  [QB][3];
    t_quo  n_quo  [QB][3];

    // restoring division, one quotient bit per stage, three lanes
    always_comb begin
        t_dn dv;
        dv = i_den << (QB - 1);
        for (int l = 0; l < 3; l++) begin
            if (i_num[l] >= dv) begin
                n_rem[0][l] = i_num[l] - dv;
                n_quo[0][l] = t_quo'(1) << (QB - 1);
            end else begin
                n_rem[0][l] = i_num[l];
                n_quo[0][l] = '0;
            end
        end
        for (int k = 1; k < QB; k++) begin
            dv = r_den[k-1] << (QB - 1 - k);
            for (int l = 0; l < 3; l++) begin
                if (r_rem[k-1][l] >= dv) begin
                    n_rem[k][l] = r_rem[k-1][l] - dv;
                    n_quo[k][l] = r_quo[k-1][l] | (t_quo'(1) << (QB - 1 - k));
                end else begin
                    n_rem[k][l] = r_rem[k-1][l];
                    n_quo[k][l] = r_quo[k-1][l];
                end
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < QB; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // advance remainders, quotients and side data
    always_ff @(posedge i_clk) begin
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 1; k < QB; k++) begin
            r_den[k]  <= r_den[k-1];
            r_side[k] <= r_side[k-1];
        end
        for (int k = 0; k < QB; k++) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[k][l] <= n_rem[k][l];
                r_quo[k][l] <= n_quo[k][l];
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_side  = r_side[QB-1];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_quo[QB-1][l];
        end
    end

endmodule

FILE: hw/rtl/segment_segment_intersection_3d.sv
// channel   direction  handshake              payload
// request   in         start && !busy         i_start1_*, i_end1_*, i_start2_*, i_end2_*
// result    out        o_done (one cycle)     o_hit_kind, o_point_x/y/z
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle; every request gives one result.
// A request passes through the split wide multiplies (32x32 digits) and then
// the 34-stage quotient divider for the point.
// Reset (synchronous, active low) clears the valid bits and loads the default
// tolerances; no memory to sweep. busy stays low and the result side never stalls.
module segment_segment_intersection_3d import ssi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start1_x,
    input  logic signed [31:0] i_start1_y,
    input  logic signed [31:0] i_start1_z,
    input  logic signed [31:0] i_end1_x,
    input  logic signed [31:0] i_end1_y,
    input  logic signed [31:0] i_end1_z,
    input  logic signed [31:0] i_start2_x,
    input  logic signed [31:0] i_start2_y,
    input  logic signed [31:0] i_start2_z,
    input  logic signed [31:0] i_end2_x,
    input  logic signed [31:0] i_end2_y,
    input  logic signed [31:0] i_end2_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_done,
    output logic [2:0]         o_hit_kind,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z
);

    localparam int LATENCY = 52;
    localparam logic signed [35:0] QOFF = 36'sh2_0000_0000;

    logic  accept;
    t_crd  in_p [12];

    logic [31:0] r_det_eps, r_coin_eps, r_zero_eps;
    logic [63:0] r_zz, r_cc;

    logic  r_v   [1:14];
    t_pts  r_pts [1:14];
    t_dif  r_d1  [1:6][3];
    t_dif  r_d2  [1:6][3];
    t_dif  r_u   [1:6][3];

    t_pp   r_pa2 [3], r_pb2 [3], r_pc2 [3], r_pd2 [3], r_pe2 [3], r_pf2 [3];
    t_dot  r_a3, r_b3, r_c3, r_d3, r_e3, r_f3;
    logic  r_len4, r_len5, r_len6;
    t_ppa  r_ppac4, r_ppbb4, r_ppbe4, r_ppcd4, r_ppbd4, r_ppae4;
    t_w    r_ac5, r_bb5, r_be5, r_cd5, r_bd5, r_ae5;
    t_w    r_det6, r_sn6, r_tn6;

    logic  r_none7, r_par7;
    t_w    r_lo7, r_det7, r_sn7, r_tn7;
    t_ppa  r_ppud7 [3], r_ppsd7 [3], r_pptd7 [3];
    t_ppa  r_ppzd7, r_ppg7;

    logic  r_none8;
    t_w    r_ud8 [3], r_sd8 [3], r_td8 [3];
    t_w    r_zd8, r_g8, r_det8, r_sn8, r_tn8;
    t_w    r_nk9 [3];
    t_w    r_g9;
    t_ppa  r_ppsq10 [3];
    t_ppa  r_pplim10;
    t_q    r_sqrow11 [3][6];
    t_q    r_limrow11 [6];
    t_q    r_sq12 [3];
    t_q    r_lim12, r_lim13, r_tot13;

    logic  r_none  [9:13];
    t_kind r_ep    [9:13];
    t_w    r_det_c [9:14];
    t_dn   r_num   [9:14][3];
    t_kind r_kind14;

    t_w    n_s16, n_t16, n_hi, n_ep_sd, n_ep_td;
    logic  n_win;
    t_kind n_ep;
    t_dn   n_num [3];
    t_dn   n_num_pk [2:0];

    logic        w_div_valid;
    t_quo [2:0]  w_quo;
    t_side       w_side;
    t_dn  [2:0]  w_num;
    t_side       w_side_in;

    logic  r_va, r_vb, r_vc;
    t_kind r_kinda, r_kindb, r_kindc;
    t_pts  r_ptsa, r_ptsb, r_ptsc;
    t_crd  r_pta [3], r_ptb [3], r_ptc [3];
    t_pp   r_dq [4][3];
    t_dot  r_sqd [4];

    logic        r_done;
    logic [2:0]  r_hit_kind;
    t_crd        r_out [3];
    t_crd        n_pt [3];
    t_kind       n_kind;
    t_crd        n_out [3];
    logic [35:0] n_sum_raw;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign in_p[0]  = i_start1_x;  assign in_p[1]  = i_start1_y;  assign in_p[2]  = i_start1_z;
    assign in_p[3]  = i_end1_x;    assign in_p[4]  = i_end1_y;    assign in_p[5]  = i_end1_z;
    assign in_p[6]  = i_start2_x;  assign in_p[7]  = i_start2_y;  assign in_p[8]  = i_start2_z;
    assign in_p[9]  = i_end2_x;    assign in_p[10] = i_end2_y;    assign in_p[11] = i_end2_z;

    function automatic t_dot sum3(input t_pp x0, input t_pp x1, input t_pp x2);
        return t_dot'(x0) + t_dot'(x1) + t_dot'(x2);
    endfunction

    // hold tolerance registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_eps  <= 32'd1;
            r_coin_eps <= 32'd65;
            r_zero_eps <= 32'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DET_EPS:  r_det_eps  <= i_cfg_data;
                CFG_COIN_EPS: r_coin_eps <= i_cfg_data;
                CFG_ZERO_EPS: r_zero_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // squared tolerances
    always_ff @(posedge i_clk) begin
        r_zz <= 64'(r_zero_eps) * 64'(r_zero_eps);
        r_cc <= 64'(r_coin_eps) * 64'(r_coin_eps);
    end

    // advance valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 14; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_v[1] <= accept;
            for (int s = 2; s <= 14; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // take the request, form direction and offset vectors, carry them along
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 12; i++) begin
            r_pts[1][i] <= in_p[i];
        end
        for (int s = 2; s <= 14; s++) begin
            r_pts[s] <= r_pts[s-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_d1[1][k] <= t_dif'(in_p[3+k]) - t_dif'(in_p[k]);
            r_d2[1][k] <= t_dif'(in_p[9+k]) - t_dif'(in_p[6+k]);
            r_u[1][k]  <= t_dif'(in_p[k])   - t_dif'(in_p[6+k]);
            for (int s = 2; s <= 6; s++) begin
                r_d1[s][k] <= r_d1[s-1][k];
                r_d2[s][k] <= r_d2[s-1][k];
                r_u[s][k]  <= r_u[s-1][k];
            end
        end
    end

    // dot products, then the wide 2x2 terms
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_pa2[k] <= r_d1[1][k] * r_d1[1][k];
            r_pb2[k] <= r_d1[1][k] * r_d2[1][k];
            r_pc2[k] <= r_d2[1][k] * r_d2[1][k];
            r_pd2[k] <= r_d1[1][k] * r_u[1][k];
            r_pe2[k] <= r_d2[1][k] * r_u[1][k];
            r_pf2[k] <= r_u[1][k]  * r_u[1][k];
        end
        r_a3 <= sum3(r_pa2[0], r_pa2[1], r_pa2[2]);
        r_b3 <= sum3(r_pb2[0], r_pb2[1], r_pb2[2]);
        r_c3 <= sum3(r_pc2[0], r_pc2[1], r_pc2[2]);
        r_d3 <= sum3(r_pd2[0], r_pd2[1], r_pd2[2]);
        r_e3 <= sum3(r_pe2[0], r_pe2[1], r_pe2[2]);
        r_f3 <= sum3(r_pf2[0], r_pf2[1], r_pf2[2]);

        r_len4  <= (r_a3 < t_dot'(r_zz)) || (r_c3 < t_dot'(r_zz)) || (r_f3 < t_dot'(r_zz));
        r_ppac4 <= mk_pp(t_w'(r_a3), t_w'(r_c3), 3, 3);
        r_ppbb4 <= mk_pp(t_w'(r_b3), t_w'(r_b3), 3, 3);
        r_ppbe4 <= mk_pp(t_w'(r_b3), t_w'(r_e3), 3, 3);
        r_ppcd4 <= mk_pp(t_w'(r_c3), t_w'(r_d3), 3, 3);
        r_ppbd4 <= mk_pp(t_w'(r_b3), t_w'(r_d3), 3, 3);
        r_ppae4 <= mk_pp(t_w'(r_a3), t_w'(r_e3), 3, 3);

        r_len5 <= r_len4;
        r_ac5  <= sum_w(r_ppac4);
        r_bb5  <= sum_w(r_ppbb4);
        r_be5  <= sum_w(r_ppbe4);
        r_cd5  <= sum_w(r_ppcd4);
        r_bd5  <= sum_w(r_ppbd4);
        r_ae5  <= sum_w(r_ppae4);

        r_len6 <= r_len5;
        r_det6 <= r_ac5 - r_bb5;
        r_sn6  <= r_be5 - r_cd5;
        r_tn6  <= r_bd5 - r_ae5;
    end

    // parallel test and the products with the determinant
    always_ff @(posedge i_clk) begin
        r_none7 <= r_len6;
        r_par7  <= (r_det6 <= 0) || (r_det6 < t_w'({r_det_eps, 48'd0}));
        r_lo7   <= (r_det6 <<< 3) + (r_det6 <<< 2) + r_det6;
        r_det7  <= r_det6;
        r_sn7   <= r_sn6;
        r_tn7   <= r_tn6;
        for (int k = 0; k < 3; k++) begin
            r_ppud7[k] <= mk_pp(t_w'(r_u[6][k]), r_det6, 1, 5);
            r_ppsd7[k] <= mk_pp(r_sn6, t_w'(r_d1[6][k]), 5, 1);
            r_pptd7[k] <= mk_pp(r_tn6, t_w'(r_d2[6][k]), 5, 1);
        end
        r_ppzd7 <= mk_pp(r_det6, t_w'(r_zero_eps), 5, 1);
        r_ppg7  <= mk_pp(r_det6, t_w'(r_coin_eps), 5, 1);
    end

    // window on s and t
    always_comb begin
        n_s16 = r_sn7 <<< 16;
        n_t16 = r_tn7 <<< 16;
        n_hi  = (r_det7 <<< 16) + r_lo7;
        n_win = (n_s16 < -r_lo7) || (n_s16 > n_hi) || (n_t16 > r_lo7) || (n_t16 < -n_hi);
    end

    always_ff @(posedge i_clk) begin
        r_none8 <= r_none7 || r_par7 || n_win;
        for (int k = 0; k < 3; k++) begin
            r_ud8[k] <= sum_w(r_ppud7[k]);
            r_sd8[k] <= sum_w(r_ppsd7[k]);
            r_td8[k] <= sum_w(r_pptd7[k]);
        end
        r_zd8  <= sum_w(r_ppzd7);
        r_g8   <= sum_w(r_ppg7);
        r_det8 <= r_det7;
        r_sn8  <= r_sn7;
        r_tn8  <= r_tn7;
    end

    // endpoint tests in priority order, and the offset point numerators
    always_comb begin
        n_ep_sd = (r_sn8 - r_det8) <<< 16;
        n_ep_td = (r_tn8 + r_det8) <<< 16;
        priority if (abs_w(r_sn8 <<< 16) < r_zd8) begin
            n_ep = KIND_S1;
        end else if (abs_w(n_ep_sd) < r_zd8) begin
            n_ep = KIND_E1;
        end else if (abs_w(r_tn8 <<< 16) < r_zd8) begin
            n_ep = KIND_S2;
        end else if (abs_w(n_ep_td) < r_zd8) begin
            n_ep = KIND_E2;
        end else begin
            n_ep = KIND_NONE;
        end
        for (int k = 0; k < 3; k++) begin
            n_num[k] = t_dn'((r_sd8[k] <<< 1) + r_det8 + (r_det8 <<< 34));
        end
    end

    always_ff @(posedge i_clk) begin
        r_none[9]  <= r_none8;
        r_ep[9]    <= n_ep;
        r_det_c[9] <= r_det8;
        r_g9       <= r_g8;
        for (int k = 0; k < 3; k++) begin
            r_nk9[k]    <= r_ud8[k] + r_sd8[k] + r_td8[k];
            r_num[9][k] <= n_num[k];
        end
        for (int s = 10; s <= 13; s++) begin
            r_none[s] <= r_none[s-1];
            r_ep[s]   <= r_ep[s-1];
        end
        for (int s = 10; s <= 14; s++) begin
            r_det_c[s] <= r_det_c[s-1];
            for (int k = 0; k < 3; k++) begin
                r_num[s][k] <= r_num[s-1][k];
            end
        end
    end

    // squared closest distance against its bound, scaled by det squared
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ppsq10[k] <= mk_pp(r_nk9[k], r_nk9[k], 6, 6);
        end
        r_pplim10 <= mk_pp(r_g9, r_det_c[9], 6, 5);

        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_sqrow11[k][i] <= row_q(r_ppsq10[k], i);
            end
            r_limrow11[i] <= row_q(r_pplim10, i);
        end

        for (int k = 0; k < 3; k++) begin
            r_sq12[k] <= r_sqrow11[k][0] + r_sqrow11[k][1] + r_sqrow11[k][2]
                       + r_sqrow11[k][3] + r_sqrow11[k][4] + r_sqrow11[k][5];
        end
        r_lim12 <= (r_limrow11[0] + r_limrow11[1] + r_limrow11[2]
                  + r_limrow11[3] + r_limrow11[4] + r_limrow11[5]) <<< 16;

        r_tot13 <= r_sq12[0] + r_sq12[1] + r_sq12[2];
        r_lim13 <= r_lim12;

        if (r_none[13] || (r_tot13 > r_lim13)) begin
            r_kind14 <= KIND_NONE;
        end else if (r_ep[13] != KIND_NONE) begin
            r_kind14 <= r_ep[13];
        end else begin
            r_kind14 <= KIND_NEW;
        end
    end

    // divide the point offsets by twice the determinant
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num_pk[k] = r_num[14][k];
            w_num[k]    = n_num_pk[k];
        end
        w_side_in.kind = r_kind14;
        w_side_in.pts  = r_pts[14];
    end

    ssi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[14]),
        .i_num   (w_num),
        .i_den   (t_dn'(r_det_c[14] <<< 1)),
        .i_side  (w_side_in),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_side  (w_side)
    );

    // form the point from start1 and the quotient, saturate
    always_comb begin
        n_sum_raw = '0;
        for (int k = 0; k < 3; k++) begin
            n_sum_raw = 36'($signed(w_side.pts[k])) + 36'({2'b00, w_quo[k]}) - QOFF;
            if ($signed(n_sum_raw) > 36'sh0_7FFF_FFFF) begin
                n_pt[k] = 32'sh7FFF_FFFF;
            end else if ($signed(n_sum_raw) < -36'sh0_8000_0000) begin
                n_pt[k] = -32'sh8000_0000;
            end else begin
                n_pt[k] = t_crd'(n_sum_raw[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_vc   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_va   <= w_div_valid;
            r_vb   <= r_va;
            r_vc   <= r_vb;
            r_done <= r_vc;
        end
    end

    // snap distances from the point to each endpoint
    always_ff @(posedge i_clk) begin
        r_kinda <= w_side.kind;
        r_ptsa  <= w_side.pts;
        r_kindb <= r_kinda;
        r_ptsb  <= r_ptsa;
        r_kindc <= r_kindb;
        r_ptsc  <= r_ptsb;
        for (int k = 0; k < 3; k++) begin
            r_pta[k] <= n_pt[k];
            r_ptb[k] <= r_pta[k];
            r_ptc[k] <= r_ptb[k];
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_dq[i][k] <= (t_dif'(r_pta[k]) - t_dif'($signed(r_ptsa[3*i+k])))
                            * (t_dif'(r_pta[k]) - t_dif'($signed(r_ptsa[3*i+k])));
            end
            r_sqd[i] <= sum3(r_dq[i][0], r_dq[i][1], r_dq[i][2]);
        end
    end

    // pick the result kind and point
    always_comb begin
        n_kind = r_kindc;
        for (int k = 0; k < 3; k++) begin
            n_out[k] = r_ptc[k];
        end
        if (r_kindc == KIND_NEW) begin
            priority if (r_sqd[0] < t_dot'(r_cc)) begin
                n_kind = KIND_S1;
            end else if (r_sqd[1] < t_dot'(r_cc)) begin
                n_kind = KIND_E1;
            end else if (r_sqd[2] < t_dot'(r_cc)) begin
                n_kind = KIND_S2;
            end else if (r_sqd[3] < t_dot'(r_cc)) begin
                n_kind = KIND_E2;
            end else begin
                n_kind = KIND_NEW;
            end
        end
        for (int k = 0; k < 3; k++) begin
            unique case (n_kind)
                KIND_NONE: n_out[k] = '0;
                KIND_S1:   n_out[k] = $signed(r_ptsc[k]);
                KIND_E1:   n_out[k] = $signed(r_ptsc[3+k]);
                KIND_S2:   n_out[k] = $signed(r_ptsc[6+k]);
                KIND_E2:   n_out[k] = $signed(r_ptsc[9+k]);
                default:   n_out[k] = r_ptc[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_kind <= n_kind;
        for (int k = 0; k < 3; k++) begin
            r_out[k] <= n_out[k];
        end
    end

    assign o_done     = r_done;
    assign o_hit_kind = r_hit_kind;
    assign o_point_x  = r_out[0];
    assign o_point_y  = r_out[1];
    assign o_point_z  = r_out[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("result missing after request");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without request");

    a_div_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[14] |-> ##QB w_div_valid)
        else $error("divider lost a request");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit_kind == KIND_NONE) |->
            (o_point_x == 0 && o_point_y == 0 && o_point_z == 0))
        else $error("no-crossing result carries a point");

endmodule

FILE: test/testbench.sv
module testbench;
    import ssi_pkg::*;

    typedef logic signed [31:0]  crd_t;
    typedef logic signed [383:0] wide_t;
    typedef crd_t seg_pair_t [12];

    typedef struct {
        t_kind kind;
        crd_t  x;
        crd_t  y;
        crd_t  z;
    } hit_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    crd_t        crd_in [12];
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_done;
    logic [2:0]  o_hit_kind;
    crd_t        o_point_x;
    crd_t        o_point_y;
    crd_t        o_point_z;

    // tolerance registers as the block should hold them
    logic [31:0] det_eps_m;
    logic [31:0] coin_eps_m;
    logic [31:0] zero_eps_m;

    hit_t        hits_pending [$];
    int          fail_count = 0;
    int          sent_count;
    int          hit_count = 0;
    int          cycle_count = 0;
    int          kind_seen [6] = '{default: 0};

    segment_segment_intersection_3d u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_start1_x  (crd_in[0]),
        .i_start1_y  (crd_in[1]),
        .i_start1_z  (crd_in[2]),
        .i_end1_x    (crd_in[3]),
        .i_end1_y    (crd_in[4]),
        .i_end1_z    (crd_in[5]),
        .i_start2_x  (crd_in[6]),
        .i_start2_y  (crd_in[7]),
        .i_start2_z  (crd_in[8]),
        .i_end2_x    (crd_in[9]),
        .i_end2_y    (crd_in[10]),
        .i_end2_z    (crd_in[11]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_hit_kind  (o_hit_kind),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic wide_t uw(input logic [31:0] v);
        wide_t r;
        r = '0;
        r[31:0] = v;
        return r;
    endfunction

    function automatic wide_t absw(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // compute the crossing of two segments with exact wide integers
    function automatic hit_t crossing_of(input seg_pair_t c);
        hit_t  h;
        wide_t p [4][3];
        wide_t d1 [3];
        wide_t d2 [3];
        wide_t u [3];
        wide_t pt [3];
        wide_t a, b, cc2, d, e, f, zz, cc, det, sn, tn, s16, t16, lo, hi;
        wide_t sum, lim, zd, nk, num, den, q, r, dsq, dk;
        int    i, k;
        h.kind = KIND_NONE;
        h.x = '0;
        h.y = '0;
        h.z = '0;
        for (i = 0; i < 4; i++)
            for (k = 0; k < 3; k++) p[i][k] = wide_t'(c[i * 3 + k]);
        for (k = 0; k < 3; k++) begin
            d1[k] = p[1][k] - p[0][k];
            d2[k] = p[3][k] - p[2][k];
            u[k] = p[0][k] - p[2][k];
        end
        zz = uw(zero_eps_m) * uw(zero_eps_m);
        cc = uw(coin_eps_m) * uw(coin_eps_m);
        a = 0; b = 0; cc2 = 0; d = 0; e = 0; f = 0;
        for (k = 0; k < 3; k++) begin
            a += d1[k] * d1[k];
            cc2 += d2[k] * d2[k];
            f += u[k] * u[k];
            b += d1[k] * d2[k];
            d += d1[k] * u[k];
            e += d2[k] * u[k];
        end
        if (a < zz || cc2 < zz || f < zz) return h;
        det = a * cc2 - b * b;
        if (det <= 0 || det < (uw(det_eps_m) <<< 48)) return h;
        sn = b * e - cc2 * d;
        tn = b * d - a * e;
        s16 = sn <<< 16;
        t16 = tn <<< 16;
        lo = det * 13;
        hi = det * 65549;
        if (s16 < -lo || s16 > hi || t16 > lo || t16 < -hi) return h;
        sum = 0;
        for (k = 0; k < 3; k++) begin
            nk = u[k] * det + sn * d1[k] + tn * d2[k];
            sum += nk * nk;
        end
        lim = (uw(coin_eps_m) <<< 16) * det * det;
        if (sum > lim) return h;
        zd = uw(zero_eps_m) * det;
        // endpoint hits by parameter, in priority order
        if (absw(s16) < zd) i = 0;
        else if (absw((sn - det) <<< 16) < zd) i = 1;
        else if (absw(t16) < zd) i = 2;
        else if (absw((tn + det) <<< 16) < zd) i = 3;
        else i = 4;
        if (i < 4) begin
            h.kind = t_kind'(i + 1);
            h.x = crd_t'(p[i][0]);
            h.y = crd_t'(p[i][1]);
            h.z = crd_t'(p[i][2]);
            return h;
        end
        // rounded point, ties upward, then saturated
        den = det + det;
        for (k = 0; k < 3; k++) begin
            num = 2 * sn * d1[k] + det;
            q = num / den;
            if (num < 0 && q * den != num) q = q - 1;
            r = p[0][k] + q;
            if (r < -(wide_t'(1) <<< 31)) r = -(wide_t'(1) <<< 31);
            if (r > (wide_t'(1) <<< 31) - 1) r = (wide_t'(1) <<< 31) - 1;
            pt[k] = r;
        end
        // snap to the first endpoint that lies within tolerance
        for (i = 0; i < 4; i++) begin
            dsq = 0;
            for (k = 0; k < 3; k++) begin
                dk = pt[k] - p[i][k];
                dsq += dk * dk;
            end
            if (dsq < cc) begin
                h.kind = t_kind'(i + 1);
                h.x = crd_t'(p[i][0]);
                h.y = crd_t'(p[i][1]);
                h.z = crd_t'(p[i][2]);
                return h;
            end
        end
        h.kind = KIND_NEW;
        h.x = crd_t'(pt[0]);
        h.y = crd_t'(pt[1]);
        h.z = crd_t'(pt[2]);
        return h;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // compare each result with the oldest expected hit
    always @(posedge i_clk) begin
        hit_t want;
        if (i_rst_n && o_done) begin
            if (hits_pending.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = hits_pending.pop_front();
                hit_count++;
                kind_seen[want.kind]++;
                if (o_hit_kind !== want.kind) begin
                    $error("hit_kind expected %0d actual %0d", want.kind, o_hit_kind);
                    fail_count++;
                end
                if (o_point_x !== want.x) begin
                    $error("point_x expected %0d actual %0d", want.x, o_point_x);
                    fail_count++;
                end
                if (o_point_y !== want.y) begin
                    $error("point_y expected %0d actual %0d", want.y, o_point_y);
                    fail_count++;
                end
                if (o_point_z !== want.z) begin
                    $error("point_z expected %0d actual %0d", want.z, o_point_z);
                    fail_count++;
                end
            end
        end
    end

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 55) return 0;
        if (g < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // send one request, predict it, then idle for a random gap when idle is set
    task automatic send_pair(input seg_pair_t c, input bit idle);
        logic b;
        int   g;
        for (int k = 0; k < 12; k++) crd_in[k] <= c[k];
        start <= 1'b1;
        forever begin
            @(negedge i_clk);
            b = busy;
            @(posedge i_clk);
            if (!b) break;
        end
        hits_pending.push_back(crossing_of(c));
        sent_count++;
        g = idle ? gap_len() : 0;
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // hold off until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] v);
        logic r;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        forever begin
            @(negedge i_clk);
            r = o_cfg_ready;
            @(posedge i_clk);
            if (r) break;
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DET_EPS:  det_eps_m = v;
            CFG_COIN_EPS: coin_eps_m = v;
            CFG_ZERO_EPS: zero_eps_m = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_tolerances(input logic [31:0] de, input logic [31:0] ce,
                                  input logic [31:0] ze);
        drain();
        write_reg(CFG_DET_EPS, de);
        write_reg(CFG_COIN_EPS, ce);
        write_reg(CFG_ZERO_EPS, ze);
    endtask

    // build two segments that cross near p at fractions f1, f2 (Q16.16 of length)
    function automatic seg_pair_t crossing_pair(input longint px, input longint py,
                                                input longint pz, input longint da[3],
                                                input longint db[3], input longint f1,
                                                input longint f2, input longint jit);
        seg_pair_t c;
        longint    pp[3];
        pp[0] = px; pp[1] = py; pp[2] = pz;
        for (int k = 0; k < 3; k++) begin
            c[k] = crd_t'(pp[k] - ((f1 * da[k]) >>> 16));
            c[3 + k] = crd_t'(pp[k] - ((f1 * da[k]) >>> 16) + da[k]);
            c[6 + k] = crd_t'(pp[k] + jit - ((f2 * db[k]) >>> 16));
            c[9 + k] = crd_t'(pp[k] + jit - ((f2 * db[k]) >>> 16) + db[k]);
        end
        return c;
    endfunction

    function automatic longint rnd_span(input int bits);
        return longint'($urandom_range(0, (1 << bits) - 1)) - longint'(1 << (bits - 1));
    endfunction

    function automatic seg_pair_t random_crossing();
        longint da[3], db[3], f1, f2, jit;
        int     sel;
        for (int k = 0; k < 3; k++) begin
            da[k] = rnd_span($urandom_range(4, 22));
            db[k] = rnd_span($urandom_range(4, 22));
        end
        sel = $urandom_range(0, 9);
        f1 = (sel == 0) ? 0 : (sel == 1) ? 65536 : $urandom_range(0, 65536);
        sel = $urandom_range(0, 9);
        f2 = (sel == 0) ? 0 : (sel == 1) ? 65536 : $urandom_range(0, 65536);
        jit = ($urandom_range(0, 3) == 0) ? rnd_span(12) : 0;
        return crossing_pair(rnd_span(28), rnd_span(28), rnd_span(28), da, db, f1, f2, jit);
    endfunction

    function automatic seg_pair_t random_noise();
        seg_pair_t c;
        int        sel;
        for (int k = 0; k < 12; k++) c[k] = crd_t'($urandom());
        sel = $urandom_range(0, 3);
        // degenerate shapes: zero length, shared start, parallel
        if (sel == 0) for (int k = 0; k < 3; k++) c[3 + k] = c[k];
        if (sel == 1) for (int k = 0; k < 3; k++) c[6 + k] = c[k];
        if (sel == 2)
            for (int k = 0; k < 3; k++) c[9 + k] = c[6 + k] + (c[3 + k] - c[k]) / 2;
        return c;
    endfunction

    task automatic test_directed();
        seg_pair_t c;
        longint    da[3], db[3];
        da[0] = 65536; da[1] = 0; da[2] = 0;
        db[0] = 0; db[1] = 65536; db[2] = 0;
        // zero-length first segment, zero-length second, shared start
        c = crossing_pair(0, 0, 0, da, db, 32768, 32768, 0);
        for (int k = 0; k < 3; k++) c[3 + k] = c[k];
        send_pair(c, 1);
        c = crossing_pair(0, 0, 0, da, db, 32768, 32768, 0);
        for (int k = 0; k < 3; k++) c[9 + k] = c[6 + k];
        send_pair(c, 1);
        c = crossing_pair(0, 0, 0, da, db, 0, 0, 0);
        send_pair(c, 1);
        // parallel lines, det exactly zero
        c = crossing_pair(0, 0, 0, da, da, 100, 200, 5000);
        send_pair(c, 1);
        // outside the parameter window on each side
        send_pair(crossing_pair(0, 0, 0, da, db, -1000, 32768, 0), 1);
        send_pair(crossing_pair(0, 0, 0, da, db, 67000, 32768, 0), 1);
        send_pair(crossing_pair(0, 0, 0, da, db, 32768, -1000, 0), 1);
        send_pair(crossing_pair(0, 0, 0, da, db, 32768, 67000, 0), 1);
        // skew lines too far apart
        db[2] = 0;
        c = crossing_pair(0, 0, 0, da, db, 32768, 32768, 0);
        for (int k = 0; k < 2; k++) begin
            c[8] = 100000;
            c[11] = 100000;
        end
        send_pair(c, 1);
        // each endpoint, a new point, near-endpoint snapping
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 0, 20000, 0), 1);
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 65536, 20000, 0), 1);
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 20000, 0, 0), 1);
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 20000, 65536, 0), 1);
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 20000, 40000, 0), 0);
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 1, 40000, 0), 0);
        send_pair(crossing_pair(1000, 2000, 3000, da, db, 65535, 40000, 3), 1);
        // coordinate extremes
        for (int k = 0; k < 12; k++) c[k] = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
        send_pair(c, 1);
        for (int k = 0; k < 12; k++) c[k] = (k < 6) ? 32'sh80000000 : 32'sh7fffffff;
        c[3] = 32'sh7fffffff;
        c[10] = 32'sh80000000;
        send_pair(c, 1);
        da[0] = 64'sh7fffffff; da[1] = -64'sh7fffffff; da[2] = 64'sh40000000;
        db[0] = -64'sh7fffffff; db[1] = -64'sh7fffffff; db[2] = 64'sh7fffffff;
        send_pair(crossing_pair(0, 0, 0, da, db, 30000, 30000, 0), 1);
        send_pair(crossing_pair(64'sh7ffff000, -64'sh7ffff000, 0, da, db, 45000, 10000, 0), 1);
    endtask

    task automatic test_random(input int n);
        seg_pair_t c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 75) c = random_crossing();
            else c = random_noise();
            send_pair(c, ($urandom_range(0, 199) > i % 200) ? 1'b1 : 1'b0);
        end
    endtask

    task automatic test_reset_tolerances();
        test_directed();
        test_random(280);
    endtask

    task automatic test_zero_tolerances();
        set_tolerances(32'd0, 32'd0, 32'd0);
        test_directed();
        test_random(150);
    endtask

    task automatic test_max_tolerances();
        set_tolerances(32'hffffffff, 32'hffffffff, 32'hffffffff);
        test_random(60);
        set_tolerances(32'd0, 32'hffffffff, 32'd0);
        test_random(100);
    endtask

    task automatic test_random_tolerances();
        for (int ph = 0; ph < 4; ph++) begin
            set_tolerances($urandom_range(0, 4), $urandom_range(0, 1 << ph * 6),
                           $urandom_range(0, 300));
            test_random(120);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DET_EPS;
        i_cfg_data = '0;
        for (int k = 0; k < 12; k++) crd_in[k] = '0;
        det_eps_m = 32'd1;
        coin_eps_m = 32'd65;
        zero_eps_m = 32'd1;
        sent_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tolerances();
        test_zero_tolerances();
        test_max_tolerances();
        test_random_tolerances();
        set_tolerances(32'd1, 32'd65, 32'd1);
        test_random(30);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d segment pairs sent, %0d results checked, over nine tolerance sets",
                 sent_count, hit_count);
        $display("tb: kinds none/s1/e1/s2/e2/new seen %0d/%0d/%0d/%0d/%0d/%0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (fail_count == 0 && hits_pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_div.sv
hw/rtl/segment_segment_intersection_3d.sv
test/testbench.sv
